@@ design/pll_pkg.sv @@
// Shared types for the pooled linked list engine: request and response words,
// request and status codes, sequencer states and the node memory command.
// No dependencies.
package pll_pkg;

  // request codes
  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_ERASE  = 2'd1,
    REQ_FIND   = 2'd2,
    REQ_NOP    = 2'd3
  } req_e;

  // response status codes
  typedef enum logic [1:0] {
    STS_OK         = 2'd0,
    STS_POOL_EMPTY = 2'd1,
    STS_NOT_FOUND  = 2'd2,
    STS_NO_ERASE   = 2'd3
  } status_e;

  // input word
  typedef struct packed {
    req_e               req_type;
    logic signed [31:0] item_value;
    logic [10:0]        prev_index;
    logic               prev_is_head;
  } pll_req_t;

  // output word
  typedef struct packed {
    status_e     status;
    logic [10:0] node_index;
    logic        found_at_head;
    logic [11:0] list_size;
  } pll_rsp_t;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_INS_PREV,
    S_INS_CHK,
    S_INS_NODE,
    S_INS_LINK,
    S_ERS_HEAD,
    S_ERS_PREV,
    S_ERS_PTR,
    S_ERS_FREE,
    S_FND_CMP,
    S_DONE
  } state_e;

  // write strobes toward the node memory
  typedef struct packed {
    logic link_we;
    logic value_we;
    logic member;
  } mem_cmd_t;

endpackage

@@ design/pooled_linked_list_engine.sv @@
// Pooled linked list engine: one singly linked list held in a fixed node pool
// with a free list of unused nodes. Each request word is taken while the block is
// idle and answered by exactly one response word. The sequencer makes one node
// memory access a cycle. Insert reads the free list head and, unless at the head,
// checks the predecessor, then writes the new node and the predecessor's link;
// erase reads the head or the predecessor and its successor, then relinks and
// frees the node; find compares one node per access along the list. Errors
// caught before any memory read and the unused request need no memory access.
// The next request word can be taken in the cycle after the response moves to
// the output register. The pool needs no clearing pass after reset: a fill count
// marks nodes never touched, which read as linked to the next index.
// The input stall stays high for the whole request; a finished response sits in
// the output register and does not block the next request unless the previous
// response is still held there.
// Depends on pll_pkg, pll_node_mem and pll_ctrl.
module pooled_linked_list_engine #(
  parameter int POOL_NODES = 2048,
  parameter int VALUE_BITS = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  pll_pkg::pll_req_t in_word_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output pll_pkg::pll_rsp_t out_word_o
);
  import pll_pkg::*;

  localparam int PTR_W = $clog2(POOL_NODES + 1);
  localparam int IDX_W = $clog2(POOL_NODES);

  mem_cmd_t              cmd;
  logic [IDX_W-1:0]      wr_addr;
  logic [PTR_W-1:0]      wr_link;
  logic [VALUE_BITS-1:0] wr_value;
  logic [IDX_W-1:0]      rd_addr;
  logic [PTR_W-1:0]      rd_link;
  logic                  rd_member;
  logic [VALUE_BITS-1:0] rd_value;
  logic                  res_ready;
  logic                  res_push;
  pll_rsp_t              res;

  logic     out_valid_q, out_valid_d;
  pll_rsp_t out_word_q, out_word_d;

  pll_ctrl #(
    .POOL_NODES(POOL_NODES),
    .VALUE_BITS(VALUE_BITS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .req_i      (in_word_i),
    .res_ready_i(res_ready),
    .res_push_o (res_push),
    .res_o      (res),
    .cmd_o      (cmd),
    .wr_addr_o  (wr_addr),
    .wr_link_o  (wr_link),
    .wr_value_o (wr_value),
    .rd_addr_o  (rd_addr),
    .rd_link_i  (rd_link),
    .rd_member_i(rd_member),
    .rd_value_i (rd_value)
  );

  pll_node_mem #(
    .POOL_NODES(POOL_NODES),
    .VALUE_BITS(VALUE_BITS)
  ) u_mem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .wr_addr_i  (wr_addr),
    .wr_link_i  (wr_link),
    .wr_value_i (wr_value),
    .rd_addr_i  (rd_addr),
    .rd_link_o  (rd_link),
    .rd_member_o(rd_member),
    .rd_value_o (rd_value)
  );

  // output register: free, or emptied in this cycle
  assign res_ready = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    out_word_d  = out_word_q;
    if (res_push) begin
      out_valid_d = 1'b1;
      out_word_d  = res;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_word_q <= out_word_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

@@ design/pll_node_mem.sv @@
// Node memory of the pooled linked list engine: link and membership store, value
// store, and the fill count that stands in for the reset chain of untouched nodes.
// Depends on pll_pkg.
module pll_node_mem #(
  parameter int POOL_NODES = 2048,
  parameter int VALUE_BITS = 32,
  localparam int PTR_W = $clog2(POOL_NODES + 1),
  localparam int IDX_W = $clog2(POOL_NODES)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  pll_pkg::mem_cmd_t     cmd_i,
  input  logic [IDX_W-1:0]      wr_addr_i,
  input  logic [PTR_W-1:0]      wr_link_i,
  input  logic [VALUE_BITS-1:0] wr_value_i,
  input  logic [IDX_W-1:0]      rd_addr_i,
  output logic [PTR_W-1:0]      rd_link_o,
  output logic                  rd_member_o,
  output logic [VALUE_BITS-1:0] rd_value_o
);
  import pll_pkg::*;

  localparam logic [PTR_W-1:0] NIL = PTR_W'(POOL_NODES);

  // {member, link} per node, and node values
  logic [PTR_W:0]        link_mem [POOL_NODES];
  logic [VALUE_BITS-1:0] value_mem [POOL_NODES];

  logic [PTR_W:0]        link_rd_q;
  logic [VALUE_BITS-1:0] value_rd_q;
  logic [IDX_W-1:0]      rd_addr_q;
  logic                  fresh_q;
  logic [PTR_W-1:0]      fill_q;
  logic [PTR_W-1:0]      fill_d;
  logic                  fresh_d;

  // memory write and registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.link_we) begin
      link_mem[wr_addr_i] <= {cmd_i.member, wr_link_i};
    end
    if (cmd_i.value_we) begin
      value_mem[wr_addr_i] <= wr_value_i;
    end
    link_rd_q  <= link_mem[rd_addr_i];
    value_rd_q <= value_mem[rd_addr_i];
    rd_addr_q  <= rd_addr_i;
  end

  // nodes at or above the fill count were never written
  always_comb begin
    fill_d  = fill_q;
    fresh_d = PTR_W'(rd_addr_i) >= fill_q;
    if (cmd_i.link_we && (PTR_W'(wr_addr_i) == fill_q)) begin
      fill_d = fill_q + PTR_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q  <= '0;
      fresh_q <= 1'b1;
    end else begin
      fill_q  <= fill_d;
      fresh_q <= fresh_d;
    end
  end

  // an untouched node links to the next index and is not in the list
  assign rd_link_o   = fresh_q ? (PTR_W'(rd_addr_q) + PTR_W'(1)) : link_rd_q[PTR_W-1:0];
  assign rd_member_o = !fresh_q && link_rd_q[PTR_W];
  assign rd_value_o  = value_rd_q;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= NIL)
    else $error("fill count beyond pool");

  a_fill_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.link_we |-> PTR_W'(wr_addr_i) <= fill_q)
    else $error("link write skips untouched nodes");

endmodule

@@ design/pll_ctrl.sv @@
// Sequencer of the pooled linked list engine: list pointers, node count and the
// per-request walk over the node memory. Depends on pll_pkg.
module pll_ctrl #(
  parameter int POOL_NODES = 2048,
  parameter int VALUE_BITS = 32,
  localparam int PTR_W = $clog2(POOL_NODES + 1),
  localparam int IDX_W = $clog2(POOL_NODES)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  pll_pkg::pll_req_t     req_i,
  input  logic                  res_ready_i,
  output logic                  res_push_o,
  output pll_pkg::pll_rsp_t     res_o,
  output pll_pkg::mem_cmd_t     cmd_o,
  output logic [IDX_W-1:0]      wr_addr_o,
  output logic [PTR_W-1:0]      wr_link_o,
  output logic [VALUE_BITS-1:0] wr_value_o,
  output logic [IDX_W-1:0]      rd_addr_o,
  input  logic [PTR_W-1:0]      rd_link_i,
  input  logic                  rd_member_i,
  input  logic [VALUE_BITS-1:0] rd_value_i
);
  import pll_pkg::*;

  localparam logic [PTR_W-1:0] NIL = PTR_W'(POOL_NODES);

  state_e           state_q, state_d;
  pll_req_t         req_q, req_d;
  pll_rsp_t         res_q, res_d;
  logic [PTR_W-1:0] head_q, head_d;
  logic [PTR_W-1:0] free_q, free_d;
  logic [PTR_W-1:0] count_q, count_d;
  logic [PTR_W-1:0] lnk_q, lnk_d;
  logic [PTR_W-1:0] cur_q, cur_d;
  logic [PTR_W-1:0] pre_q, pre_d;
  logic [PTR_W-1:0] np_q, np_d;

  logic                  prev_ok;
  logic [IDX_W-1:0]      prev_addr;
  logic [VALUE_BITS-1:0] key;
  logic [PTR_W-1:0]      count_dec;

  assign prev_ok    = 32'(req_q.prev_index) < 32'(POOL_NODES);
  assign prev_addr  = IDX_W'(req_q.prev_index);
  assign key        = VALUE_BITS'(req_q.item_value);
  assign count_dec  = (count_q != '0) ? (count_q - PTR_W'(1)) : count_q;
  assign wr_value_o = key;

  // state and payload registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      head_q  <= NIL;
      free_q  <= '0;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      free_q  <= free_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    res_q <= res_d;
    lnk_q <= lnk_d;
    cur_q <= cur_d;
    pre_q <= pre_d;
    np_q  <= np_d;
  end

  // next state, memory accesses and result
  always_comb begin
    state_d    = state_q;
    req_d      = req_q;
    res_d      = res_q;
    head_d     = head_q;
    free_d     = free_q;
    count_d    = count_q;
    lnk_d      = lnk_q;
    cur_d      = cur_q;
    pre_d      = pre_q;
    np_d       = np_q;
    cmd_o      = '0;
    wr_addr_o  = '0;
    wr_link_o  = '0;
    rd_addr_o  = '0;
    res_push_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          req_d   = req_i;
          state_d = S_START;
        end
      end
      S_START: begin
        unique case (req_q.req_type)
          REQ_INSERT: begin
            if (free_q == NIL) begin
              res_d   = '{STS_POOL_EMPTY, 11'd0, 1'b0, 12'd0};
              state_d = S_DONE;
            end else if (!req_q.prev_is_head && !prev_ok) begin
              res_d   = '{STS_NOT_FOUND, 11'd0, 1'b0, 12'd0};
              state_d = S_DONE;
            end else begin
              rd_addr_o = IDX_W'(free_q);
              state_d   = S_INS_PREV;
            end
          end
          REQ_ERASE: begin
            if (head_q == NIL) begin
              res_d   = '{STS_NO_ERASE, 11'd0, 1'b0, 12'd0};
              state_d = S_DONE;
            end else if (req_q.prev_is_head) begin
              rd_addr_o = IDX_W'(head_q);
              state_d   = S_ERS_HEAD;
            end else if (!prev_ok) begin
              res_d   = '{STS_NOT_FOUND, 11'd0, 1'b0, 12'd0};
              state_d = S_DONE;
            end else begin
              rd_addr_o = prev_addr;
              state_d   = S_ERS_PREV;
            end
          end
          REQ_FIND: begin
            if (head_q == NIL) begin
              res_d   = '{STS_NOT_FOUND, 11'd0, 1'b0, 12'd0};
              state_d = S_DONE;
            end else begin
              rd_addr_o = IDX_W'(head_q);
              cur_d     = head_q;
              pre_d     = NIL;
              state_d   = S_FND_CMP;
            end
          end
          default: begin
            res_d   = '{STS_OK, 11'd0, 1'b0, 12'd0};
            state_d = S_DONE;
          end
        endcase
      end
      // free list successor arrives, fetch the predecessor if any
      S_INS_PREV: begin
        lnk_d = rd_link_i;
        if (req_q.prev_is_head) begin
          cur_d   = head_q;
          state_d = S_INS_NODE;
        end else begin
          rd_addr_o = prev_addr;
          state_d   = S_INS_CHK;
        end
      end
      S_INS_CHK: begin
        if (!rd_member_i) begin
          res_d   = '{STS_NOT_FOUND, 11'd0, 1'b0, 12'd0};
          state_d = S_DONE;
        end else begin
          cur_d   = rd_link_i;
          state_d = S_INS_NODE;
        end
      end
      // write the new node and pop it off the free list
      S_INS_NODE: begin
        cmd_o     = '{link_we: 1'b1, value_we: 1'b1, member: 1'b1};
        wr_addr_o = IDX_W'(free_q);
        wr_link_o = cur_q;
        np_d      = free_q;
        free_d    = lnk_q;
        count_d   = count_q + PTR_W'(1);
        if (req_q.prev_is_head) begin
          head_d  = free_q;
          res_d   = '{STS_OK, 11'(free_q), 1'b0, 12'd0};
          state_d = S_DONE;
        end else begin
          state_d = S_INS_LINK;
        end
      end
      S_INS_LINK: begin
        cmd_o     = '{link_we: 1'b1, value_we: 1'b0, member: 1'b1};
        wr_addr_o = prev_addr;
        wr_link_o = np_q;
        res_d     = '{STS_OK, 11'(np_q), 1'b0, 12'd0};
        state_d   = S_DONE;
      end
      // unlink the head and push it on the free list
      S_ERS_HEAD: begin
        cmd_o     = '{link_we: 1'b1, value_we: 1'b0, member: 1'b0};
        wr_addr_o = IDX_W'(head_q);
        wr_link_o = free_q;
        head_d    = rd_link_i;
        free_d    = head_q;
        count_d   = count_dec;
        res_d     = '{STS_OK, 11'(head_q), 1'b0, 12'd0};
        state_d   = S_DONE;
      end
      S_ERS_PREV: begin
        if (!rd_member_i) begin
          res_d   = '{STS_NOT_FOUND, 11'd0, 1'b0, 12'd0};
          state_d = S_DONE;
        end else if (rd_link_i == NIL) begin
          res_d   = '{STS_NO_ERASE, 11'd0, 1'b0, 12'd0};
          state_d = S_DONE;
        end else begin
          np_d      = rd_link_i;
          rd_addr_o = IDX_W'(rd_link_i);
          state_d   = S_ERS_PTR;
        end
      end
      // bridge the predecessor over the erased node
      S_ERS_PTR: begin
        cmd_o     = '{link_we: 1'b1, value_we: 1'b0, member: 1'b1};
        wr_addr_o = prev_addr;
        wr_link_o = rd_link_i;
        state_d   = S_ERS_FREE;
      end
      S_ERS_FREE: begin
        cmd_o     = '{link_we: 1'b1, value_we: 1'b0, member: 1'b0};
        wr_addr_o = IDX_W'(np_q);
        wr_link_o = free_q;
        free_d    = np_q;
        count_d   = count_dec;
        res_d     = '{STS_OK, 11'(np_q), 1'b0, 12'd0};
        state_d   = S_DONE;
      end
      // one node per cycle: compare, then follow the link
      S_FND_CMP: begin
        if (rd_value_i == key) begin
          if (pre_q == NIL) begin
            res_d = '{STS_OK, 11'd0, 1'b1, 12'd0};
          end else begin
            res_d = '{STS_OK, 11'(pre_q), 1'b0, 12'd0};
          end
          state_d = S_DONE;
        end else if (rd_link_i == NIL) begin
          res_d   = '{STS_NOT_FOUND, 11'd0, 1'b0, 12'd0};
          state_d = S_DONE;
        end else begin
          pre_d     = cur_q;
          cur_d     = rd_link_i;
          rd_addr_o = IDX_W'(rd_link_i);
        end
      end
      S_DONE: begin
        if (res_ready_i) begin
          res_push_o = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign in_stall_o = (state_q != S_IDLE);

  // list size is taken from the count after the request
  always_comb begin
    res_o           = res_q;
    res_o.list_size = 12'(count_q);
  end

  a_empty_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) == (head_q == NIL))
    else $error("head pointer and node count disagree");

  a_pool_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (free_q == NIL) |-> (count_q == NIL))
    else $error("free list empty while pool not full");

  a_insert_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_INS_NODE) |=> (count_q == $past(count_q) + PTR_W'(1)))
    else $error("insert did not grow the list");

endmodule

@@ verif/tb_top.sv @@
// Self-checking testbench for pooled_linked_list_engine: drives request words,
// predicts every response word with a shadow of the node pool, and checks them.
// Depends on pll_pkg and the pooled_linked_list_engine RTL.
`timescale 1ns / 1ps

module tb_top;
  import pll_pkg::*;

  localparam int          POOL = 2048;
  localparam logic [11:0] NIL  = 12'd2048;

  // shadow of the node pool, free list and list; holds the awaited responses
  class list_tracker;
    logic [11:0] next_of  [POOL];
    logic [31:0] value_of [POOL];
    bit          on_list  [POOL];
    logic [11:0] head_ptr;
    logic [11:0] free_ptr;
    int          node_cnt;
    int          peak_cnt;
    pll_rsp_t    awaited_rsp [$];
    int          status_seen [4];
    int          bad_words;
    int          checked;

    function new();
      for (int i = 0; i < POOL; i++) begin
        next_of[i]  = 12'(i + 1);
        value_of[i] = '0;
        on_list[i]  = 1'b0;
      end
      head_ptr  = NIL;
      free_ptr  = '0;
      node_cnt  = 0;
      peak_cnt  = 0;
      bad_words = 0;
      checked   = 0;
      for (int i = 0; i < 4; i++) status_seen[i] = 0;
    endfunction

    // walk n links from the head
    function int nth_node(int n);
      logic [11:0] p;
      p = head_ptr;
      repeat (n) p = next_of[p];
      return int'(p);
    endfunction

    // some node currently on the list, list must not be empty
    function int any_member();
      int idx;
      if (node_cnt <= 64) return nth_node($urandom_range(0, node_cnt - 1));
      do idx = $urandom_range(0, POOL - 1); while (!on_list[idx]);
      return idx;
    endfunction

    // apply one accepted request word and queue the response it must produce
    function void take_request(pll_req_t w);
      pll_rsp_t    r;
      logic [11:0] prev;
      logic [11:0] node;
      logic [11:0] pre;
      logic [11:0] p;
      logic [31:0] v;
      bit          unlink;
      int          steps;
      r      = '0;
      prev   = {1'b0, w.prev_index};
      v      = w.item_value;
      unlink = 1'b0;
      node   = NIL;
      case (w.req_type)
        REQ_INSERT: begin
          if (free_ptr == NIL) begin
            r.status = STS_POOL_EMPTY;
          end else if (!w.prev_is_head && !on_list[prev]) begin
            r.status = STS_NOT_FOUND;
          end else begin
            node           = free_ptr;
            free_ptr       = next_of[node];
            value_of[node] = v;
            if (w.prev_is_head) begin
              next_of[node] = head_ptr;
              head_ptr      = node;
            end else begin
              next_of[node] = next_of[prev];
              next_of[prev] = node;
            end
            on_list[node] = 1'b1;
            node_cnt++;
            r.node_index = node[10:0];
          end
        end
        REQ_ERASE: begin
          if (head_ptr == NIL) begin
            r.status = STS_NO_ERASE;
          end else if (w.prev_is_head) begin
            node     = head_ptr;
            head_ptr = next_of[node];
            unlink   = 1'b1;
          end else if (!on_list[prev]) begin
            r.status = STS_NOT_FOUND;
          end else if (next_of[prev] == NIL) begin
            r.status = STS_NO_ERASE;
          end else begin
            node          = next_of[prev];
            next_of[prev] = next_of[node];
            unlink        = 1'b1;
          end
          // freed node goes to the front of the free list
          if (unlink) begin
            next_of[node] = free_ptr;
            free_ptr      = node;
            on_list[node] = 1'b0;
            if (node_cnt > 0) node_cnt--;
            r.node_index = node[10:0];
          end
        end
        REQ_FIND: begin
          pre   = NIL;
          p     = head_ptr;
          steps = 0;
          while (p != NIL && steps < POOL && value_of[p] != v) begin
            pre = p;
            p   = next_of[p];
            steps++;
          end
          if (p != NIL && steps < POOL) begin
            if (pre == NIL) r.found_at_head = 1'b1;
            else r.node_index = pre[10:0];
          end else begin
            r.status = STS_NOT_FOUND;
          end
        end
        default: ;
      endcase
      r.list_size = 12'(node_cnt);
      if (node_cnt > peak_cnt) peak_cnt = node_cnt;
      awaited_rsp.push_back(r);
    endfunction

    // compare one accepted response word with the oldest awaited one
    function void check_response(pll_rsp_t got);
      pll_rsp_t want;
      checked++;
      if (got.status inside {STS_OK, STS_POOL_EMPTY, STS_NOT_FOUND, STS_NO_ERASE})
        status_seen[got.status]++;
      if (awaited_rsp.size() == 0) begin
        if (bad_words < 10) $display("unexpected response word %h", got);
        bad_words++;
        return;
      end
      want = awaited_rsp.pop_front();
      if (got.status !== want.status || got.node_index !== want.node_index ||
          got.found_at_head !== want.found_at_head ||
          got.list_size !== want.list_size) begin
        if (bad_words < 10)
          $display({"mismatch: expected sts %0d node %0d head %0b size %0d, ",
                    "got sts %0d node %0d head %0b size %0d"},
                   want.status, want.node_index, want.found_at_head, want.list_size,
                   got.status, got.node_index, got.found_at_head, got.list_size);
        bad_words++;
      end
    endfunction

    function int failures();
      return bad_words + awaited_rsp.size();
    endfunction
  endclass

  logic     clk_i;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  logic     in_stall_o;
  pll_req_t in_word_i   = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  pll_rsp_t out_word_o;

  list_tracker tracker    = new();
  bit          quiet_send = 1'b0;
  int          sent       = 0;

  pooled_linked_list_engine i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

  // clock and reset
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // run limit
  initial begin
    #8ms;
    $display("pooled_linked_list_engine regression: fail");
    $finish;
  end

  function automatic pll_req_t make_word(req_e op, logic [31:0] v, int prev, bit at_head);
    pll_req_t w;
    w.req_type     = op;
    w.item_value   = v;
    w.prev_index   = 11'(prev);
    w.prev_is_head = at_head;
    return w;
  endfunction

  // offer one word after an optional random gap, hold it until taken
  task automatic send_word(input pll_req_t w);
    while (!quiet_send && $urandom_range(0, 99) < 22) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    do @(posedge clk_i); while (in_stall_o);
    tracker.take_request(w);
    sent++;
  endtask

  // one random request, weighted to keep the list short but busy
  task automatic send_random_word();
    int          roll;
    int          ins_lim;
    int          prev;
    bit          at_head;
    logic [31:0] v;
    req_e        op;
    int          cnt;
    cnt     = tracker.node_cnt;
    ins_lim = (cnt < 4) ? 60 : (cnt > 40) ? 20 : 38;
    roll    = $urandom_range(0, 99);
    if (roll < ins_lim) op = REQ_INSERT;
    else if (roll < ins_lim + 30) op = REQ_ERASE;
    else if (roll < 98) op = REQ_FIND;
    else op = REQ_NOP;
    // values: a small set so finds hit duplicates, copies of list values, or noise
    roll = $urandom_range(0, 99);
    if (roll < 40) v = 32'($urandom_range(0, 7)) - 32'd3;
    else if (roll < 65 && cnt > 0) v = tracker.value_of[tracker.any_member()];
    else v = $urandom;
    if (op == REQ_FIND && cnt > 0 && $urandom_range(0, 99) < 40)
      v = tracker.value_of[tracker.any_member()];
    // predecessor: mostly a node on the list, sometimes any index
    at_head = ($urandom_range(0, 99) < 30);
    if (cnt > 0 && $urandom_range(0, 99) < 85) prev = tracker.any_member();
    else prev = $urandom_range(0, POOL - 1);
    send_word(make_word(op, v, prev, at_head));
  endtask

  // response side: random stalls, one long hold-off, one stretch without stalls
  initial begin : receiver
    int hold_left;
    int seen;
    hold_left = 0;
    seen      = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        tracker.check_response(out_word_o);
        seen++;
        if (seen == 300) hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (seen >= 500 && seen < 700) begin
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < 22);
      end
    end
  end

  // request side
  initial begin : stimulus
    wait (rst_ni);
    @(posedge clk_i);

    // directed: empty list, field extremes, every request kind and every error case but a full pool
    send_word(make_word(REQ_ERASE,  32'd0,         0,    1'b1));
    send_word(make_word(REQ_FIND,   32'd0,         0,    1'b0));
    send_word(make_word(REQ_INSERT, 32'd9,         5,    1'b0));
    send_word(make_word(REQ_ERASE,  32'd0,         0,    1'b0));
    send_word(make_word(REQ_INSERT, 32'h7fffffff,  0,    1'b1));
    send_word(make_word(REQ_INSERT, 32'h80000000,  0,    1'b1));
    send_word(make_word(REQ_INSERT, 32'd0,         0,    1'b0));
    send_word(make_word(REQ_INSERT, 32'hffffffff,  2,    1'b0));
    send_word(make_word(REQ_FIND,   32'h80000000,  0,    1'b0));
    send_word(make_word(REQ_FIND,   32'hffffffff,  0,    1'b0));
    send_word(make_word(REQ_FIND,   32'd12345,     0,    1'b0));
    send_word(make_word(REQ_ERASE,  32'd0,         3,    1'b0));
    send_word(make_word(REQ_ERASE,  32'd0,         2047, 1'b0));
    send_word(make_word(REQ_INSERT, 32'd1,         2047, 1'b0));
    send_word(make_word(REQ_ERASE,  32'd0,         0,    1'b0));
    send_word(make_word(REQ_FIND,   32'd0,         0,    1'b0));
    send_word(make_word(REQ_ERASE,  32'd0,         0,    1'b1));
    send_word(make_word(REQ_NOP,    32'hffffffff,  2047, 1'b1));
    send_word(make_word(REQ_INSERT, 32'd0,         2047, 1'b1));
    send_word(make_word(REQ_ERASE,  32'hffffffff,  2047, 1'b1));
    send_word(make_word(REQ_FIND,   32'h7fffffff,  0,    1'b1));

    // random mix, with one stretch of back-to-back words
    for (int i = 0; i < 450; i++) begin
      quiet_send = (i >= 150 && i < 300);
      send_random_word();
    end
    quiet_send = 1'b0;

    // grow the list to a few hundred nodes
    repeat (250) begin
      if (tracker.node_cnt == 0 || $urandom_range(0, 1) == 0)
        send_word(make_word(REQ_INSERT, $urandom, $urandom_range(0, POOL - 1), 1'b1));
      else
        send_word(make_word(REQ_INSERT, $urandom, tracker.any_member(), 1'b0));
    end

    // long walks over the whole list
    send_word(make_word(REQ_FIND,
                        tracker.value_of[tracker.nth_node(tracker.node_cnt - 1)],
                        0, 1'b0));
    send_word(make_word(REQ_FIND, $urandom, 0, 1'b0));

    // drain the list back to empty
    while (tracker.node_cnt > 0) begin
      if (tracker.node_cnt > 64 && $urandom_range(0, 1) == 0)
        send_word(make_word(REQ_ERASE, $urandom, tracker.any_member(), 1'b0));
      else
        send_word(make_word(REQ_ERASE, $urandom, $urandom_range(0, POOL - 1), 1'b1));
    end
    send_word(make_word(REQ_ERASE, 32'd0, 0, 1'b1));
    in_valid_i <= 1'b0;

    // wait for the last responses, then a short quiet period
    while (tracker.awaited_rsp.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);

    $display("covered %0d request words and %0d response words, peak list size %0d",
             sent, tracker.checked, tracker.peak_cnt);
    $display("statuses seen: ok %0d, pool empty %0d, not found %0d, nothing to erase %0d",
             tracker.status_seen[STS_OK], tracker.status_seen[STS_POOL_EMPTY],
             tracker.status_seen[STS_NOT_FOUND], tracker.status_seen[STS_NO_ERASE]);
    if (tracker.failures() == 0) begin
      $display("pooled_linked_list_engine regression: pass");
    end else begin
      $display("pooled_linked_list_engine regression: fail");
    end
    $finish;
  end

endmodule
